@@ hw/rtl/mi3_pkg.sv @@
// Shared widths, types and stage counts for the 3x3 matrix inverse pipeline.
package mi3_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int NEL        = 9;

	localparam int PROD_W = 2 * DATA_WIDTH;
	localparam int COF_W  = 2 * DATA_WIDTH + 1;
	localparam int PP_W   = 2 * DATA_WIDTH + 1;
	localparam int DET_W  = 3 * DATA_WIDTH + 1;
	localparam int DMAG_W = 3 * DATA_WIDTH;
	localparam int CABS_W = 2 * DATA_WIDTH;
	localparam int NUM_W  = (2 * DATA_WIDTH + 2 * FRAC_BITS > 3 * DATA_WIDTH) ?
		2 * DATA_WIDTH + 2 * FRAC_BITS + 2 : 3 * DATA_WIDTH + 2;
	localparam int DD_W   = DMAG_W + 1;
	localparam int CMP_W  = NUM_W + DATA_WIDTH + 1;

	// divider: numerator prep, overflow check, one stage per quotient bit, clip
	localparam int DIV_ST = DATA_WIDTH + 3;
	// input, products, cofactors, det partials, det terms, det, magnitudes, divider
	localparam int NST    = 7 + DIV_ST;

	typedef logic signed [DATA_WIDTH-1:0] elem_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [COF_W-1:0]      cof_t;
	typedef logic signed [DET_W-1:0]      det_t;

	typedef struct packed {
		logic [NEL-1:0][DATA_WIDTH-1:0] r;
		logic                           singular;
		logic                           saturated;
	} res_t;

endpackage

@@ hw/rtl/mi3_cof.sv @@
// Input register, minor products and the nine cofactors.
module mi3_cof import mi3_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  elem_t m_in   [NEL],
	output elem_t m_s3   [NEL],
	output cof_t  cof_s3 [NEL]
);

	elem_t m_s1 [NEL];
	elem_t m_s2 [NEL];
	prod_t pa_s2 [NEL];
	prod_t pb_s2 [NEL];

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= m_in;
			m_s2 <= m_s1;
			m_s3 <= m_s2;
		end
	end

	for (genvar i = 0; i < NEL; i++) begin : g_cof
		localparam int R  = i / 3;
		localparam int C  = i % 3;
		localparam int R1 = (R + 1) % 3;
		localparam int R2 = (R + 2) % 3;
		localparam int C1 = (C + 1) % 3;
		localparam int C2 = (C + 2) % 3;

		always_ff @(posedge clk) begin
			if (en) begin
				pa_s2[i]  <= m_s1[R1*3+C1] * m_s1[R2*3+C2];
				pb_s2[i]  <= m_s1[R1*3+C2] * m_s1[R2*3+C1];
				cof_s3[i] <= COF_W'(pa_s2[i]) - COF_W'(pb_s2[i]);
			end
		end
	end

endmodule

@@ hw/rtl/mi3_det.sv @@
// Determinant by expansion along row 0, with split partial products.
module mi3_det import mi3_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  elem_t m_s3   [NEL],
	input  cof_t  cof_s3 [NEL],
	output det_t  det_s6,
	output cof_t  cof_s6 [NEL]
);

	logic signed [DATA_WIDTH:0] lo_op [3];
	logic signed [DATA_WIDTH:0] hi_op [3];
	logic signed [PP_W-1:0]     plo_s4 [3];
	logic signed [PP_W-1:0]     phi_s4 [3];
	det_t                       term_s5 [3];
	cof_t                       cof_s4 [NEL];
	cof_t                       cof_s5 [NEL];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			lo_op[j] = $signed({1'b0, cof_s3[j][DATA_WIDTH-1:0]});
			hi_op[j] = cof_s3[j][COF_W-1:DATA_WIDTH];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				plo_s4[j]  <= m_s3[j] * lo_op[j];
				phi_s4[j]  <= m_s3[j] * hi_op[j];
				term_s5[j] <= (DET_W'(phi_s4[j]) <<< DATA_WIDTH) + DET_W'(plo_s4[j]);
			end
			det_s6 <= term_s5[0] + term_s5[1] + term_s5[2];
			cof_s4 <= cof_s3;
			cof_s5 <= cof_s4;
			cof_s6 <= cof_s5;
		end
	end

endmodule

@@ hw/rtl/mi3_div.sv @@
// Nine-lane restoring divider, one quotient bit per stage, rounding and clipping.
module mi3_div import mi3_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [CABS_W-1:0] cabs_s7 [NEL],
	input  logic [NEL-1:0]    neg_s7,
	input  logic [DMAG_W-1:0] dmag_s7,
	output elem_t             quo_sf  [NEL],
	output logic [NEL-1:0]    sat_sf
);

	localparam logic [DATA_WIDTH-1:0] LIM_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] LIM_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic [NUM_W-1:0]      rem_s  [0:DATA_WIDTH][NEL];
	logic [DATA_WIDTH-1:0] quot_s [2:DATA_WIDTH+1][NEL];
	logic [NEL-1:0]        ovf_s  [1:DATA_WIDTH+1];
	logic [NEL-1:0]        neg_s  [0:DATA_WIDTH+1];
	logic [DD_W-1:0]       dd_s   [0:DATA_WIDTH];

	// numerator 2*|C|*2^(2F) + |D| and divisor 2*|D| give round half away from zero
	always_ff @(posedge clk) begin
		if (en) begin
			dd_s[0]  <= DD_W'(dmag_s7) << 1;
			neg_s[0] <= neg_s7;
			for (int i = 0; i < NEL; i++)
				rem_s[0][i] <= (NUM_W'(cabs_s7[i]) << (2 * FRAC_BITS + 1)) + NUM_W'(dmag_s7);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dd_s[1]  <= dd_s[0];
			neg_s[1] <= neg_s[0];
			for (int i = 0; i < NEL; i++) begin
				rem_s[1][i] <= rem_s[0][i];
				ovf_s[1][i] <= CMP_W'(rem_s[0][i]) >= (CMP_W'(dd_s[0]) << DATA_WIDTH);
			end
		end
	end

	for (genvar t = 0; t < DATA_WIDTH; t++) begin : g_step
		localparam int K = DATA_WIDTH - 1 - t;

		logic [NEL-1:0]        take;
		logic [CMP_W-1:0]      diff [NEL];
		logic [DATA_WIDTH-1:0] qprev [NEL];

		if (t == 0) begin : g_q0
			always_comb begin
				for (int i = 0; i < NEL; i++)
					qprev[i] = '0;
			end
		end else begin : g_qn
			always_comb begin
				for (int i = 0; i < NEL; i++)
					qprev[i] = quot_s[1+t][i];
			end
		end

		always_comb begin
			for (int i = 0; i < NEL; i++) begin
				take[i] = CMP_W'(rem_s[1+t][i]) >= (CMP_W'(dd_s[1+t]) << K);
				diff[i] = CMP_W'(rem_s[1+t][i]) - (CMP_W'(dd_s[1+t]) << K);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[2+t] <= neg_s[1+t];
				ovf_s[2+t] <= ovf_s[1+t];
				for (int i = 0; i < NEL; i++)
					quot_s[2+t][i] <= {qprev[i][DATA_WIDTH-2:0], take[i]};
			end
		end

		if (t < DATA_WIDTH - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					dd_s[2+t] <= dd_s[1+t];
					for (int i = 0; i < NEL; i++)
						rem_s[2+t][i] <= take[i] ? NUM_W'(diff[i]) : rem_s[1+t][i];
				end
			end
		end
	end

	logic [DATA_WIDTH-1:0] lim [NEL];
	logic [DATA_WIDTH-1:0] mag [NEL];
	logic [NEL-1:0]        clip;

	always_comb begin
		for (int i = 0; i < NEL; i++) begin
			lim[i]  = neg_s[DATA_WIDTH+1][i] ? LIM_NEG : LIM_POS;
			clip[i] = ovf_s[DATA_WIDTH+1][i] || (quot_s[DATA_WIDTH+1][i] > lim[i]);
			mag[i]  = clip[i] ? lim[i] : quot_s[DATA_WIDTH+1][i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_sf <= clip;
			for (int i = 0; i < NEL; i++)
				quo_sf[i] <= neg_s[DATA_WIDTH+1][i] ? elem_t'(DATA_WIDTH'(0) - mag[i])
					: elem_t'(mag[i]);
		end
	end

endmodule

@@ hw/rtl/mi3_obuf.sv @@
// Two-entry result buffer between the pipeline and the output channel.
module mi3_obuf import mi3_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t din,
	input  logic pop,
	output logic full,
	output logic valid,
	output res_t dout
);

	res_t       mem [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign dout  = mem[rd_q];

endmodule

@@ hw/rtl/matrix_inverse_3x3.sv @@
// Top level: 3x3 fixed-point matrix inverse by the adjugate.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------
//  input    | in_valid / in_ready     | m00 .. m22, signed Q16.16
//  output   | out_valid / out_ready   | r00 .. r22, singular, saturated
//
// One matrix per cycle while the output buffer has room. Most of the pipeline is
// the divider, which has one pipeline stage for each quotient bit.
// The pipeline advances as a whole while the two-entry output buffer has room;
// in_ready falls only when both entries hold untaken results.
// Reset clears the valid bits and the buffer pointers; no clearing pass.
module matrix_inverse_3x3 import mi3_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  elem_t m00,
	input  elem_t m01,
	input  elem_t m02,
	input  elem_t m10,
	input  elem_t m11,
	input  elem_t m12,
	input  elem_t m20,
	input  elem_t m21,
	input  elem_t m22,
	output logic  out_valid,
	input  logic  out_ready,
	output elem_t r00,
	output elem_t r01,
	output elem_t r02,
	output elem_t r10,
	output elem_t r11,
	output elem_t r12,
	output elem_t r20,
	output elem_t r21,
	output elem_t r22,
	output logic  singular,
	output logic  saturated
);

	logic              en;
	logic              full;
	logic [1:NST]      vld_s;
	elem_t             m_in    [NEL];
	elem_t             m_s3    [NEL];
	cof_t              cof_s3  [NEL];
	cof_t              cof_s6  [NEL];
	det_t              det_s6;
	logic              sing_s7;
	logic [DMAG_W-1:0] dmag_s7;
	logic [CABS_W-1:0] cabs_s7 [NEL];
	logic [NEL-1:0]    neg_s7;
	elem_t             quo_sf  [NEL];
	logic [NEL-1:0]    sat_sf;
	elem_t             m_d     [4:NST][NEL];
	logic              sing_d  [8:NST];
	res_t              din;
	res_t              dout;

	assign m_in[0] = m00;
	assign m_in[1] = m01;
	assign m_in[2] = m02;
	assign m_in[3] = m10;
	assign m_in[4] = m11;
	assign m_in[5] = m12;
	assign m_in[6] = m20;
	assign m_in[7] = m21;
	assign m_in[8] = m22;

	assign en       = ~full;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {in_valid, vld_s[1:NST-1]};
	end

	mi3_cof u_cof (
		.clk    (clk),
		.en     (en),
		.m_in   (m_in),
		.m_s3   (m_s3),
		.cof_s3 (cof_s3)
	);

	mi3_det u_det (
		.clk    (clk),
		.en     (en),
		.m_s3   (m_s3),
		.cof_s3 (cof_s3),
		.det_s6 (det_s6),
		.cof_s6 (cof_s6)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sing_s7 <= (det_s6 == '0);
			dmag_s7 <= det_s6[DET_W-1] ? DMAG_W'(-det_s6) : DMAG_W'(det_s6);
		end
	end

	// result (r,c) takes cofactor (c,r)
	for (genvar i = 0; i < NEL; i++) begin : g_mag
		localparam int T = (i % 3) * 3 + i / 3;

		always_ff @(posedge clk) begin
			if (en) begin
				cabs_s7[i] <= cof_s6[T][COF_W-1] ? CABS_W'(-cof_s6[T]) : CABS_W'(cof_s6[T]);
				neg_s7[i]  <= cof_s6[T][COF_W-1] ^ det_s6[DET_W-1];
			end
		end
	end

	mi3_div u_div (
		.clk     (clk),
		.en      (en),
		.cabs_s7 (cabs_s7),
		.neg_s7  (neg_s7),
		.dmag_s7 (dmag_s7),
		.quo_sf  (quo_sf),
		.sat_sf  (sat_sf)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			m_d[4]    <= m_s3;
			sing_d[8] <= sing_s7;
		end
	end

	for (genvar k = 5; k <= NST; k++) begin : g_mdly
		always_ff @(posedge clk) begin
			if (en)
				m_d[k] <= m_d[k-1];
		end
	end

	for (genvar k = 9; k <= NST; k++) begin : g_sdly
		always_ff @(posedge clk) begin
			if (en)
				sing_d[k] <= sing_d[k-1];
		end
	end

	always_comb begin
		for (int i = 0; i < NEL; i++)
			din.r[i] = sing_d[NST] ? m_d[NST][i] : quo_sf[i];
		din.singular  = sing_d[NST];
		din.saturated = ~sing_d[NST] & (|sat_sf);
	end

	mi3_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (en & vld_s[NST]),
		.din    (din),
		.pop    (out_valid & out_ready),
		.full   (full),
		.valid  (out_valid),
		.dout   (dout)
	);

	assign r00       = dout.r[0];
	assign r01       = dout.r[1];
	assign r02       = dout.r[2];
	assign r10       = dout.r[3];
	assign r11       = dout.r[4];
	assign r12       = dout.r[5];
	assign r20       = dout.r[6];
	assign r21       = dout.r[7];
	assign r22       = dout.r[8];
	assign singular  = dout.singular;
	assign saturated = dout.saturated;

endmodule

@@ hw/rtl/mi3_chk.sv @@
// Port-level checker for the matrix inverse top, attached by bind.
module mi3_chk import mi3_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input logic  out_valid,
	input logic  out_ready,
	input elem_t r00,
	input logic  singular,
	input logic  saturated
);

	localparam int CAP = NST + 2;
	localparam int CW  = $clog2(CAP + 2);

	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else
			cnt_q <= cnt_q + CW'(in_valid & in_ready) - CW'(out_valid & out_ready);
	end

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != '0)
		else $error("result shown with no matrix in flight");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAP))
		else $error("more matrices in flight than the pipeline holds");

	a_sing_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> !saturated)
		else $error("singular result flagged saturated");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(r00) && $stable(singular)
			&& $stable(saturated))
		else $error("stalled result changed");

endmodule

bind matrix_inverse_3x3 mi3_chk u_mi3_chk (.*);

@@ tb/matrix_inverse_3x3_tb.sv @@
// Testbench for matrix_inverse_3x3: exact-arithmetic prediction, scoreboard, random stalls.
`timescale 1ns / 1ps

module matrix_inverse_3x3_tb import mi3_pkg::*;;

	typedef logic [NEL-1:0][DATA_WIDTH-1:0] mat_t;

	localparam logic [31:0] ONE  = 32'h0001_0000;
	localparam logic [31:0] EMAX = 32'h7fff_ffff;
	localparam logic [31:0] EMIN = 32'h8000_0000;

	typedef enum int {MK_FULL, MK_WELL, MK_SING, MK_TINY, MK_EXTREME} mat_kind_t;

	function automatic res_t inverse_of(mat_t m);
		logic signed [127:0] a[9];
		logic signed [127:0] cof[9];
		logic signed [127:0] det, num;
		logic [127:0] nmag, dmag, q, rem, limit;
		logic neg;
		int r1, r2, c1, c2;
		res_t res;
		for (int i = 0; i < 9; i++)
			a[i] = {{96{m[i][31]}}, m[i]};
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				r1 = (r + 1) % 3; r2 = (r + 2) % 3;
				c1 = (c + 1) % 3; c2 = (c + 2) % 3;
				cof[r*3+c] = a[r1*3+c1] * a[r2*3+c2] - a[r1*3+c2] * a[r2*3+c1];
			end
		end
		det = a[0] * cof[0] + a[1] * cof[1] + a[2] * cof[2];
		res.saturated = 1'b0;
		res.singular  = 1'b0;
		if (det == 0) begin
			res.r = m;
			res.singular = 1'b1;
			return res;
		end
		dmag = det[127] ? -det : det;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				num  = cof[c*3+r] <<< (2 * FRAC_BITS);
				neg  = num[127] ^ det[127];
				nmag = num[127] ? -num : num;
				q    = nmag / dmag;
				rem  = nmag % dmag;
				if ((rem << 1) >= dmag)
					q = q + 1;
				limit = neg ? 128'h8000_0000 : 128'h7fff_ffff;
				if (q > limit) begin
					q = limit;
					res.saturated = 1'b1;
				end
				if (neg)
					q = -q;
				res.r[r*3+c] = q[31:0];
			end
		end
		return res;
	endfunction

	class inverse_scoreboard;
		res_t pending[$];
		int errors = 0;

		function void note_matrix(mat_t m);
			pending.push_back(inverse_of(m));
		endfunction

		function void check_result(res_t act);
			res_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result r00=%h", $time, act.r[0]);
				errors++;
				return;
			end
			exp = pending.pop_front();
			for (int i = 0; i < NEL; i++)
				if (act.r[i] !== exp.r[i]) begin
					$display("%0t: r%0d%0d expected %h actual %h", $time, i / 3, i % 3,
						exp.r[i], act.r[i]);
					errors++;
				end
			if (act.singular !== exp.singular) begin
				$display("%0t: singular expected %b actual %b", $time, exp.singular,
					act.singular);
				errors++;
			end
			if (act.saturated !== exp.saturated) begin
				$display("%0t: saturated expected %b actual %b", $time, exp.saturated,
					act.saturated);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	logic in_ready, out_valid, singular, saturated;
	mat_t cur = '0;
	elem_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
	int idle_pct = 7;
	bit hold_req = 0;
	inverse_scoreboard sb = new();

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	matrix_inverse_3x3 dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.m00(cur[0]), .m01(cur[1]), .m02(cur[2]),
		.m10(cur[3]), .m11(cur[4]), .m12(cur[5]),
		.m20(cur[6]), .m21(cur[7]), .m22(cur[8]),
		.out_valid(out_valid), .out_ready(out_ready),
		.r00(r00), .r01(r01), .r02(r02),
		.r10(r10), .r11(r11), .r12(r12),
		.r20(r20), .r21(r21), .r22(r22),
		.singular(singular), .saturated(saturated)
	);

	always @(posedge clk) begin
		res_t act;
		if (arst_n && in_valid && in_ready)
			sb.note_matrix(cur);
		if (arst_n && out_valid && out_ready) begin
			act.r = {r22, r21, r20, r12, r11, r10, r02, r01, r00};
			act.singular = singular;
			act.saturated = saturated;
			sb.check_result(act);
		end
	end

	initial begin
		@(posedge clk);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	task automatic send_matrix(mat_t m);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		cur <= m;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic logic [31:0] small_val(int span);
		return 32'($signed($urandom_range(2 * span)) - span);
	endfunction

	function automatic mat_t random_matrix(mat_kind_t kind);
		mat_t m;
		logic [31:0] pick[6];
		int k;
		pick = '{EMAX, EMIN, 32'h0, ONE, 32'hffff_ffff, 32'h1};
		for (int i = 0; i < 9; i++)
			m[i] = $urandom;
		case (kind)
			MK_WELL: begin
				for (int i = 0; i < 9; i++)
					m[i] = (i % 4 == 0) ? ((($urandom_range(1) ? 1 : -1) *
						$signed($urandom_range(1 << 19, 1 << 16)))) : small_val(1 << 16);
			end
			MK_SING: begin
				k = $urandom_range(2);
				for (int i = 0; i < 9; i++)
					if ($urandom_range(1)) m[i] = small_val(1 << 18);
				if (k == 0)
					for (int c = 0; c < 3; c++) m[6+c] = m[c];
				else if (k == 1)
					for (int c = 0; c < 3; c++) m[3+c] = '0;
				else
					for (int r = 0; r < 3; r++) m[r*3+2] = m[r*3];
			end
			MK_TINY: begin
				for (int i = 0; i < 9; i++) m[i] = small_val(255);
			end
			MK_EXTREME: begin
				for (int i = 0; i < 9; i++) m[i] = pick[$urandom_range(5)];
			end
			default: ;
		endcase
		return m;
	endfunction

	initial begin
		mat_t d[$];
		mat_t m;
		int roll;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		d.push_back({ONE, 32'h0, 32'h0, 32'h0, ONE, 32'h0, 32'h0, 32'h0, ONE});
		d.push_back('0);
		d.push_back({9{EMAX}});
		d.push_back({9{EMIN}});
		d.push_back({EMAX, 32'h0, 32'h0, 32'h0, EMAX, 32'h0, 32'h0, 32'h0, EMAX});
		d.push_back({EMIN, 32'h0, 32'h0, 32'h0, EMIN, 32'h0, 32'h0, 32'h0, EMIN});
		d.push_back({EMIN, 32'h0, 32'h0, 32'h0, EMAX, 32'h0, 32'h0, 32'h0, 32'h1});
		d.push_back({32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1});
		d.push_back({32'h3_0000, 32'h0, 32'h0, 32'h0, 32'hfffe_0000, 32'h0, 32'h0,
			32'h0, 32'h7_0000});
		d.push_back({32'h0, 32'h0, ONE, 32'h0, ONE, 32'h0, ONE, 32'h0, 32'h0});
		d.push_back({ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE});
		d.push_back({32'h9_0000, 32'h8_0000, 32'h7_0000, 32'h6_0000, 32'h5_0000,
			32'h4_0000, 32'h3_0000, 32'h2_0000, 32'h1_0000});
		d.push_back({EMAX, EMIN, 32'h1, 32'h5, EMAX, EMIN, 32'hffff_ffff, 32'h2, EMAX});
		d.push_back({32'h3, 32'h0, 32'h0, 32'h0, 32'h3, 32'h0, 32'h0, 32'h0, 32'h3});
		foreach (d[i]) send_matrix(d[i]);

		for (int n = 0; n < 1700; n++) begin
			if (n == 300) begin
				in_valid <= 1'b0;
				wait (sb.pending.size() == 0);
				repeat (60) @(posedge clk);
			end
			if (n == 500) hold_req = 1;
			idle_pct = (n >= 800 && n < 1100) ? 0 : 7;
			roll = $urandom_range(99);
			if (roll < 20)      m = random_matrix(MK_FULL);
			else if (roll < 60) m = random_matrix(MK_WELL);
			else if (roll < 75) m = random_matrix(MK_SING);
			else if (roll < 90) m = random_matrix(MK_TINY);
			else                m = random_matrix(MK_EXTREME);
			send_matrix(m);
		end
		in_valid <= 1'b0;
		wait (sb.pending.size() == 0);
		repeat (60) @(posedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
